### rtl/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types and constants of the thermistor table interpolator: the
// breakpoint table, field widths and the divider interface structs.
// ----------------------------------------------------------------------------
package tti_pkg;

    // field widths
    localparam int RAW_W   = 12;
    localparam int TEMP_W  = 12;

    // breakpoint table: raw readings at 20, 25, ..., 120 degrees
    localparam int TABLE_ENTRIES = 21;
    localparam int SEG_W         = $clog2(TABLE_ENTRIES);

    localparam logic [RAW_W-1:0] BREAKPOINTS [TABLE_ENTRIES] = '{
        12'h73a, 12'h800, 12'h8be, 12'h974, 12'ha1e, 12'habc, 12'hb4c,
        12'hbcf, 12'hc45, 12'hcae, 12'hd0c, 12'hd5f, 12'hda9, 12'hdea,
        12'he24, 12'he56, 12'he83, 12'heaa, 12'hecd, 12'heec, 12'hf07
    };

    // temperature scaling in sixteenths of a degree
    localparam int BASE_TEMP = 16 * 20;
    localparam int TOP_TEMP  = 16 * (20 + 5 * (TABLE_ENTRIES - 1));

    // arithmetic widths: |raw - x0| up to 1850, times 80 up to 148000
    localparam int DIFF_W = 11;
    localparam int NUM_W  = 18;
    localparam int DEN_W  = 8;
    localparam int ACC_W  = 13;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } t_div_rsp;

endpackage

### rtl/tti_div.sv
// ----------------------------------------------------------------------------
// tti_div
// Restoring unsigned divider, one quotient bit per cycle, shared by every
// segment of the interpolation.
// ----------------------------------------------------------------------------
module tti_div
    import tti_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // one trial subtraction per cycle
    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

### rtl/thermistor_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_unit
// Converts a raw 12-bit thermistor reading to sixteenths of a degree by
// piecewise linear interpolation over a constant breakpoint table.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream takes one raw reading per transaction in tdata[11:0].
//   master stream returns one result per reading: tdata[11:0] holds the
//   temperature (two's complement, 1/16 degree, floored), tuser the clamp
//   flag, set when the reading reached the last breakpoint.
//   each reading passes the search, load, divide and finish states (divide
//   skipped when clamped); the 18-step restoring divider, one quotient bit
//   per cycle, takes most of the time. s_axis_tready is high only while the
//   block is idle, so no new reading is taken before the last is through.
//   the result waits in an output register; while the receiver stalls the
//   block goes on until one more finished reading waits behind it, then
//   holds it, taking no more readings until the output register is free.
//   reset (synchronous, active low) clears m_axis_tvalid, drops pending work
//   and returns the sequencer to idle; no table or memory needs clearing.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_unit
    import tti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] raw_reading
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [11:0] temp_sixteenths
    output logic        o_m_axis_tuser    // [0] clamped
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [RAW_W-1:0]  r_raw, n_raw;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic              r_clamp, n_clamp;
    logic              r_neg, n_neg;
    logic [TEMP_W-1:0] r_temp, n_temp;
    logic              r_out_valid, n_out_valid;
    logic [TEMP_W-1:0] r_out_temp, n_out_temp;
    logic              r_out_clamp, n_out_clamp;

    logic [SEG_W-1:0]  seg_found;
    logic              clamp_found;
    logic [RAW_W-1:0]  x0, x1;
    logic              below;
    logic [RAW_W-1:0]  span;
    logic [DIFF_W-1:0] abs_diff;
    logic [ACC_W-1:0]  base;
    logic [ACC_W-1:0]  q_adj;
    logic [ACC_W-1:0]  temp_acc;
    logic              s_accept;
    logic              slot_free;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // segment search: last inner breakpoint lying below the reading
    always_comb begin
        seg_found = '0;
        for (int k = 1; k <= TABLE_ENTRIES - 2; k++) begin
            if (r_raw > BREAKPOINTS[k]) begin
                seg_found = SEG_W'(k);
            end
        end
        clamp_found = (r_raw >= BREAKPOINTS[TABLE_ENTRIES-1]);
    end

    // segment ends, offset magnitude and scaled dividend
    always_comb begin
        x0       = BREAKPOINTS[r_seg];
        x1       = BREAKPOINTS[r_seg + 1'b1];
        below    = (r_raw < x0);
        span     = below ? (x0 - r_raw) : (r_raw - x0);
        abs_diff = span[DIFF_W-1:0];
        div_req.start    = (r_state == ST_LOAD) && !r_clamp;
        div_req.dividend = (NUM_W'(abs_diff) << 6) + (NUM_W'(abs_diff) << 4);
        div_req.divisor  = DEN_W'(x1 - x0);
    end

    // base temperature of the segment plus or minus the quotient, floored
    always_comb begin
        base  = ACC_W'(BASE_TEMP) + (ACC_W'(r_seg) << 6) + (ACC_W'(r_seg) << 4);
        q_adj = ACC_W'(div_rsp.quotient)
              + ACC_W'(r_neg && (div_rsp.remainder != '0));
        temp_acc = r_neg ? (base - q_adj) : (base + q_adj);
    end

    tti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_out_valid || i_m_axis_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_raw       = r_raw;
        n_seg       = r_seg;
        n_clamp     = r_clamp;
        n_neg       = r_neg;
        n_temp      = r_temp;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        n_out_clamp = r_out_clamp;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_raw   = i_s_axis_tdata[RAW_W-1:0];
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_seg   = seg_found;
                n_clamp = clamp_found;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_neg = below;
                if (r_clamp) begin
                    n_temp  = TEMP_W'(TOP_TEMP);
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_temp  = temp_acc[TEMP_W-1:0];
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_temp;
                    n_out_clamp = r_clamp;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_raw       <= n_raw;
        r_seg       <= n_seg;
        r_clamp     <= n_clamp;
        r_neg       <= n_neg;
        r_temp      <= n_temp;
        r_out_temp  <= n_out_temp;
        r_out_clamp <= n_out_clamp;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_temp};
    assign o_m_axis_tuser  = r_out_clamp;

endmodule
